>>> rtl/msp_pkg.sv
// Shared types and constants for the minimum-sum compatible pair search.
// Used by the store, the sequencer and the top level. No dependencies.

package msp_pkg;

  localparam int COST_W          = 32;
  localparam int SUM_W           = 33;
  localparam int IDX_W           = 6;
  localparam int SIZE_W          = 7;
  localparam int ROW_W           = 64;
  localparam int MAX_ENTRIES_DEF = 64;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_WRITE_X   = 2'd0,
    CMD_WRITE_Y   = 2'd1,
    CMD_WRITE_ROW = 2'd2,
    CMD_SEARCH    = 2'd3
  } cmd_t;

  // Registered read data from the store, for the pair being evaluated.
  typedef struct packed {
    logic signed [COST_W-1:0] x_cost;
    logic signed [COST_W-1:0] y_cost;
    logic                     compat;
  } rd_data_t;

endpackage

>>> rtl/msp_store.sv
// Cost lists and compatibility matrix, one write port for loads and one
// registered read port for the search sequencer. Depends on msp_pkg.

module msp_store #(
  parameter int MAX_ENTRIES = msp_pkg::MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES)
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic [1:0]                      command,
  input  logic [msp_pkg::IDX_W-1:0]       index,
  input  logic signed [msp_pkg::COST_W-1:0] cost_value,
  input  logic [msp_pkg::ROW_W-1:0]       compat_row,
  input  logic [AW-1:0]                   rd_x,
  input  logic [AW-1:0]                   rd_y,
  output msp_pkg::rd_data_t               rd_data
);

  localparam logic [msp_pkg::SIZE_W-1:0] DEPTH = msp_pkg::SIZE_W'(MAX_ENTRIES);

  logic signed [msp_pkg::COST_W-1:0] x_mem [MAX_ENTRIES];
  logic signed [msp_pkg::COST_W-1:0] y_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]            c_mem [MAX_ENTRIES];

  logic signed [msp_pkg::COST_W-1:0] x_q;
  logic signed [msp_pkg::COST_W-1:0] y_q;
  logic [MAX_ENTRIES-1:0]            row_q;
  logic [AW-1:0]                     col_q;

  logic          in_range;
  logic          we_x;
  logic          we_y;
  logic          we_row;
  logic [AW-1:0] wr_addr;

  assign in_range = {1'b0, index} < DEPTH;
  assign wr_addr  = index[AW-1:0];

  always_comb begin
    we_x   = 1'b0;
    we_y   = 1'b0;
    we_row = 1'b0;
    unique case (msp_pkg::cmd_t'(command))
      msp_pkg::CMD_WRITE_X:   we_x   = load && in_range;
      msp_pkg::CMD_WRITE_Y:   we_y   = load && in_range;
      msp_pkg::CMD_WRITE_ROW: we_row = load && in_range;
      msp_pkg::CMD_SEARCH:    ;
      default:                ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_x) begin
      x_mem[wr_addr] <= cost_value;
    end
    x_q <= x_mem[rd_x];
  end

  always_ff @(posedge clk) begin
    if (we_y) begin
      y_mem[wr_addr] <= cost_value;
    end
    y_q <= y_mem[rd_y];
  end

  // Only the columns below the depth are stored; higher bits are never read.
  always_ff @(posedge clk) begin
    if (we_row) begin
      c_mem[wr_addr] <= compat_row[MAX_ENTRIES-1:0];
    end
    row_q <= c_mem[rd_x];
    col_q <= rd_y;
  end

  assign rd_data.x_cost = x_q;
  assign rd_data.y_cost = y_q;
  assign rd_data.compat = row_q[col_q];

endmodule

>>> rtl/msp_seq.sv
// Search sequencer: walks the L-shaped shells one pair at a time through a
// single shared adder and comparator, and holds the result register.
// Depends on msp_pkg.

module msp_seq #(
  parameter int MAX_ENTRIES = msp_pkg::MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [msp_pkg::SIZE_W-1:0]       size_cfg,
  input  msp_pkg::rd_data_t                rd_data,
  output logic [AW-1:0]                    rd_x,
  output logic [AW-1:0]                    rd_y,
  output logic                             busy,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic [msp_pkg::IDX_W-1:0]        x_index,
  output logic [msp_pkg::IDX_W-1:0]        y_index,
  output logic signed [msp_pkg::SUM_W-1:0] best_sum
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_DONE} state_t;
  typedef enum logic [2:0] {P_ORIGIN, P_CHECK, P_ROW, P_COL, P_DIAG} phase_t;

  localparam logic [msp_pkg::SIZE_W-1:0] DEPTH = msp_pkg::SIZE_W'(MAX_ENTRIES);

  state_t  state;
  phase_t  phase;
  logic [CW-1:0] i_cnt;
  logic [CW-1:0] j_cnt;
  logic [AW-1:0] cur_x;
  logic [AW-1:0] cur_y;
  logic          have;
  logic signed [msp_pkg::SUM_W-1:0] best;
  logic [AW-1:0] bx;
  logic [AW-1:0] by;

  logic [msp_pkg::SIZE_W-1:0]       n_wide;
  logic [CW-1:0]                    n_eff;
  logic [CW-1:0]                    i_next;
  logic [CW-1:0]                    j_next;
  logic signed [msp_pkg::SUM_W-1:0] sum;
  logic                             lt;
  logic                             take;
  logic                             out_free;

  // A size of zero acts as one, and a size above the depth as the depth.
  assign n_wide = (size_cfg == '0) ? msp_pkg::SIZE_W'(1) :
                  (size_cfg > DEPTH) ? DEPTH : size_cfg;
  assign n_eff  = n_wide[CW-1:0];
  assign i_next = i_cnt + CW'(1);
  assign j_next = j_cnt + CW'(1);

  // The one adder and comparator that every step of the search shares.
  assign sum  = {rd_data.x_cost[msp_pkg::COST_W-1], rd_data.x_cost}
              + {rd_data.y_cost[msp_pkg::COST_W-1], rd_data.y_cost};
  assign lt   = sum < best;
  assign take = (state == S_EVAL) && (phase != P_CHECK) && rd_data.compat && (!have || lt);

  assign out_free = !out_valid || !out_stall;
  assign busy     = (state != S_IDLE);
  assign rd_x     = cur_x;
  assign rd_y     = cur_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_ORIGIN;
      have      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // In the done state a free result register is refilled below instead.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        have <= 1'b1;
        best <= sum;
        bx   <= cur_x;
        by   <= cur_y;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            have  <= 1'b0;
            phase <= P_ORIGIN;
            cur_x <= '0;
            cur_y <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_READ;
          unique case (phase)
            P_ORIGIN: begin
              if (rd_data.compat || n_eff == CW'(1)) begin
                state <= S_DONE;
              end else begin
                i_cnt <= CW'(1);
                phase <= P_CHECK;
              end
            end
            P_CHECK: begin
              // The shell cannot beat a best already at or below its corner sum.
              if (have && !lt) begin
                state <= S_DONE;
              end else begin
                j_cnt <= i_cnt;
                phase <= P_ROW;
                cur_x <= AW'(i_cnt - CW'(1));
                cur_y <= AW'(i_cnt);
              end
            end
            P_ROW: begin
              phase <= P_COL;
              cur_x <= cur_y;
              cur_y <= cur_x;
            end
            P_COL: begin
              if (j_next == n_eff) begin
                phase <= P_DIAG;
                cur_x <= AW'(i_cnt);
                cur_y <= AW'(i_cnt);
              end else begin
                j_cnt <= j_next;
                phase <= P_ROW;
                cur_x <= cur_y;
                cur_y <= AW'(j_next);
              end
            end
            P_DIAG: begin
              // The diagonal pair just read is also the next shell's corner.
              if (i_next == n_eff) begin
                state <= S_DONE;
              end else begin
                i_cnt <= i_next;
                phase <= P_CHECK;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            found     <= have;
            x_index   <= have ? msp_pkg::IDX_W'(bx) : '0;
            y_index   <= have ? msp_pkg::IDX_W'(by) : '0;
            best_sum  <= have ? best : '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/min_sum_compatible_pair_search_top.sv
// Top level of the minimum-sum compatible pair search.
// Instantiates msp_store and msp_seq; depends on msp_pkg.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   command, index, cost_value, compat_row
//   out      output     out_valid / out_stall found, x_index, y_index, best_sum
//   cfg      input      cfg_valid / cfg_ready size_in_use
//
// After a load beat the next beat may follow at once.
// A search reads (S_READ) and evaluates (S_EVAL) each tested pair and each shell check
// in turn through the one shared adder and comparator, then finishes in S_DONE, which
// waits while an earlier result is still stalled.
// The block stalls its input while a search runs; loads pass a waiting result.
// Reset is synchronous; it clears the control state and sets the size to 64.

module min_sum_compatible_pair_search_top #(
  parameter int MAX_ENTRIES = msp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       command,
  input  logic [msp_pkg::IDX_W-1:0]        index,
  input  logic signed [msp_pkg::COST_W-1:0] cost_value,
  input  logic [msp_pkg::ROW_W-1:0]        compat_row,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic [msp_pkg::IDX_W-1:0]        x_index,
  output logic [msp_pkg::IDX_W-1:0]        y_index,
  output logic signed [msp_pkg::SUM_W-1:0] best_sum,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [msp_pkg::SIZE_W-1:0]       size_in_use
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic [msp_pkg::SIZE_W-1:0] size_cfg;
  logic                       in_beat;
  logic                       start;
  logic                       busy;
  logic [AW-1:0]              rd_x;
  logic [AW-1:0]              rd_y;
  msp_pkg::rd_data_t          rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_beat   = in_valid && !in_stall;
  assign start     = in_beat && (command == msp_pkg::CMD_SEARCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= msp_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_cfg <= size_in_use;
    end
  end

  msp_store #(.MAX_ENTRIES(MAX_ENTRIES)) u_store (
    .clk        (clk),
    .load       (in_beat),
    .command    (command),
    .index      (index),
    .cost_value (cost_value),
    .compat_row (compat_row),
    .rd_x       (rd_x),
    .rd_y       (rd_y),
    .rd_data    (rd_data)
  );

  msp_seq #(.MAX_ENTRIES(MAX_ENTRIES)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .size_cfg  (size_cfg),
    .rd_data   (rd_data),
    .rd_x      (rd_x),
    .rd_y      (rd_y),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .x_index   (x_index),
    .y_index   (y_index),
    .best_sum  (best_sum)
  );

`ifndef SYNTHESIS
  // A search beat always occupies the sequencer in the following cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> in_stall)
    else $error("search beat did not start the sequencer");

  // A load beat never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && in_beat && command != msp_pkg::CMD_SEARCH) |=> !out_valid)
    else $error("load beat produced a result");

  // A not-found result carries all-zero fields.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (x_index == '0 && y_index == '0 && best_sum == '0))
    else $error("not-found result has nonzero fields");
`endif

endmodule
